[design/led_driver_command_encoder_core_assert.svh]
// Assertion macros used by the LED-driver command encoder back end.
`ifndef LED_DRIVER_COMMAND_ENCODER_CORE_ASSERT_SVH
`define LED_DRIVER_COMMAND_ENCODER_CORE_ASSERT_SVH

// Clocked check, skipped while reset is asserted.
`define LDCE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define LDCE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/ldce_pkg.sv]
// Types, constants and helpers shared by the LED-driver command encoder.
package ldce_pkg;

  localparam int VALUE_BITS    = 16;
  localparam int CASCADE_COUNT = 10;
  localparam int MAX_CLOCKS    = 248;
  localparam int CMD_BITS      = CASCADE_COUNT * VALUE_BITS;
  localparam int PH_W          = $clog2(VALUE_BITS);
  localparam int SAMPLE_W      = 12;
  localparam int SAMPLES_PER_RESULT = 4;

  localparam logic [SAMPLE_W-1:0] RED_LANES   = 12'h0C3;
  localparam logic [SAMPLE_W-1:0] GREEN_LANES = 12'h30C;
  localparam logic [SAMPLE_W-1:0] BLUE_LANES  = 12'hC30;

  typedef struct packed {
    logic [7:0]  requested_clocks;
    logic [7:0]  high_clocks;
    logic        has_data;
    logic [15:0] red_value;
    logic [15:0] green_value;
    logic [15:0] blue_value;
  } in_req_t;

  typedef struct packed {
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic        second_valid;
    logic        is_header;
    logic        rejected;
    logic        last_of_run;
  } out_res_t;

  // Classified command passed from the front to the back
  typedef struct packed {
    logic        rejected;
    logic [7:0]  low_m1;
    logic [7:0]  high_m1;
    logic        has_data;
    logic [7:0]  pad;
    logic [5:0]  nres_m1;
    logic [15:0] red_value;
    logic [15:0] green_value;
    logic [15:0] blue_value;
  } cmd_t;

  // Spread one bit of each color onto its lanes
  function automatic logic [SAMPLE_W-1:0] lane_sample(input logic r, input logic g,
                                                      input logic b);
    logic [SAMPLE_W-1:0] s;
    s = '0;
    if (r) s = s | RED_LANES;
    if (g) s = s | GREEN_LANES;
    if (b) s = s | BLUE_LANES;
    return s;
  endfunction

endpackage

[design/ldce_front.sv]
// Front end: rounds the clock count, validates the request, builds a command.
module ldce_front (
  input  ldce_pkg::in_req_t req,
  output ldce_pkg::cmd_t    cmd
);
  import ldce_pkg::*;

  logic [8:0] clocks;
  logic [8:0] high9;
  logic       bad;

  // Round up to a multiple of eight
  assign clocks = ({1'b0, req.requested_clocks} + 9'd7) & ~9'd7;
  assign high9  = {1'b0, req.high_clocks};

  // Reject bad high count, too many clocks, or data that does not fit
  assign bad = (req.high_clocks == 8'd0) || (high9 >= clocks) ||
               (clocks > 9'(MAX_CLOCKS)) ||
               (req.has_data && (clocks < 9'(CMD_BITS)));

  // Build the command
  always_comb begin
    cmd.rejected    = bad;
    cmd.low_m1      = 8'(clocks - high9 - 9'd1);
    cmd.high_m1     = req.high_clocks - 8'd1;
    cmd.has_data    = req.has_data;
    cmd.pad         = 8'(clocks - 9'(CMD_BITS));
    cmd.nres_m1     = 6'(clocks[8:2] - 7'd1);
    cmd.red_value   = req.red_value;
    cmd.green_value = req.green_value;
    cmd.blue_value  = req.blue_value;
  end

endmodule

[design/ldce_cmd_fifo.sv]
// Two-entry command queue between the front and the back.
module ldce_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ldce_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output ldce_pkg::cmd_t pop_data
);
  import ldce_pkg::*;

  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rp_r];

  // Advance pointers and count
  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Store the request
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

[design/ldce_back.sv]
// Back end: sequences header, sample and reject results into the output register.
`include "led_driver_command_encoder_core_assert.svh"

module ldce_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_empty,
  input  ldce_pkg::cmd_t   cmd_data,
  output logic             cmd_pop,
  output logic             res_valid,
  output ldce_pkg::out_res_t res_data,
  input  logic             res_pop
);
  import ldce_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_HEAD = 3'b010,
    S_SAMP = 3'b100
  } state_t;

  state_t     st_r, st_nxt;
  cmd_t       cmd_r;
  logic [5:0] k_r, k_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic [PH_W-1:0] ph_r, ph_nxt;
  out_res_t   out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_load;
  logic       load;

  logic [SAMPLE_W-1:0] smp [SAMPLES_PER_RESULT];
  logic [2:0]          ndata;
  logic [PH_W:0]       ph_sum;

  assign can_load  = !out_valid_r || res_pop;
  assign cmd_pop   = (st_r == S_IDLE) && !cmd_empty;
  assign res_valid = out_valid_r;
  assign res_data  = out_r;

  // Build the four samples of the current result
  always_comb begin
    logic [8:0]  pos;
    logic        dat;
    logic [PH_W:0] p;
    logic [4:0]  bpos;
    ndata = 3'd0;
    for (int s = 0; s < SAMPLES_PER_RESULT; s++) begin
      pos = {1'b0, idx_r} + 9'(s);
      dat = cmd_r.has_data && (pos >= {1'b0, cmd_r.pad});
      p   = {1'b0, ph_r} + (PH_W+1)'(ndata);
      if (p >= (PH_W+1)'(VALUE_BITS)) p = p - (PH_W+1)'(VALUE_BITS);
      bpos = 5'(VALUE_BITS - 1) - 5'(p);
      smp[s] = dat ? lane_sample(cmd_r.red_value[bpos[3:0]], cmd_r.green_value[bpos[3:0]],
                                 cmd_r.blue_value[bpos[3:0]])
                   : '0;
      ndata = ndata + 3'(dat);
    end
    ph_sum = {1'b0, ph_r} + (PH_W+1)'(ndata);
    if (ph_sum >= (PH_W+1)'(VALUE_BITS)) ph_sum = ph_sum - (PH_W+1)'(VALUE_BITS);
  end

  // Sequence one command
  always_comb begin
    st_nxt        = st_r;
    k_nxt         = k_r;
    idx_nxt       = idx_r;
    ph_nxt        = ph_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !res_pop;
    load          = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (!cmd_empty) st_nxt = S_HEAD;
      end
      S_HEAD: begin
        if (can_load) begin
          load                 = 1'b1;
          out_nxt              = '0;
          if (cmd_r.rejected) begin
            out_nxt.rejected    = 1'b1;
            out_nxt.last_of_run = 1'b1;
            st_nxt              = S_IDLE;
          end else begin
            out_nxt.first_word  = {8'd0, cmd_r.high_m1, 8'd0, cmd_r.low_m1};
            out_nxt.is_header   = 1'b1;
            st_nxt              = S_SAMP;
          end
          k_nxt   = '0;
          idx_nxt = '0;
          ph_nxt  = '0;
        end
      end
      S_SAMP: begin
        if (can_load) begin
          load                 = 1'b1;
          out_nxt.first_word   = {8'd0, smp[1], smp[0]};
          out_nxt.second_word  = {8'd0, smp[3], smp[2]};
          out_nxt.second_valid = 1'b1;
          out_nxt.is_header    = 1'b0;
          out_nxt.rejected     = 1'b0;
          out_nxt.last_of_run  = (k_r == cmd_r.nres_m1);
          k_nxt   = k_r + 6'd1;
          idx_nxt = idx_r + 8'(SAMPLES_PER_RESULT);
          ph_nxt  = PH_W'(ph_sum);
          if (k_r == cmd_r.nres_m1) st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
    if (load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload and counters
  always_ff @(posedge clk) begin
    if (cmd_pop) cmd_r <= cmd_data;
    k_r   <= k_nxt;
    idx_r <= idx_nxt;
    ph_r  <= ph_nxt;
    out_r <= out_nxt;
  end

  `LDCE_ASSERT(a_rej_last, out_valid_r && out_r.rejected |-> out_r.last_of_run, "reject not last")
  `LDCE_ASSERT(a_samp_pair, out_valid_r && !out_r.is_header && !out_r.rejected |-> out_r.second_valid, "sample result without second word")
  `LDCE_ASSERT(a_last_idle, load && out_nxt.last_of_run |=> st_r == S_IDLE, "no return to idle after last result")
  `LDCE_ASSERT(a_k_bound, st_r == S_SAMP |-> k_r <= cmd_r.nres_m1, "sample count overrun")

endmodule

[design/led_driver_command_encoder_core.sv]
// Top level of the LED-driver command encoder.
//
//  channel  | ports                       | request moved
//  ---------+-----------------------------+----------------------------------
//  input    | in_push, in_full, in_data   | one command request
//  result   | out_pop, out_empty, out_data| header, sample pair or reject
//
// A command yields one reject result, or a header plus clocks/4 sample
// results (up to 63 in all), one result per cycle while out_pop keeps up.
// The back end takes a command from the two-entry queue in its idle state
// and then emits the command's results from its header and sample states.
// The front accepts new commands while the back works until the queue fills.
// Reset is synchronous, active low, and empties the queue and output register.
module led_driver_command_encoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  ldce_pkg::in_req_t  in_data,
  output logic               out_empty,
  input  logic               out_pop,
  output ldce_pkg::out_res_t out_data
);
  import ldce_pkg::*;

  cmd_t fe_cmd;
  cmd_t q_cmd;
  logic q_empty;
  logic q_pop;
  logic res_valid;

  // Classify the request
  ldce_front u_front (
    .req (in_data),
    .cmd (fe_cmd)
  );

  // Queue classified commands
  ldce_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (fe_cmd),
    .full      (in_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .pop_data  (q_cmd)
  );

  // Emit the word run
  ldce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (q_empty),
    .cmd_data  (q_cmd),
    .cmd_pop   (q_pop),
    .res_valid (res_valid),
    .res_data  (out_data),
    .res_pop   (out_pop)
  );

  assign out_empty = !res_valid;

endmodule
